// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising edge of clk, off while rst is high.
`define SWFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Immediate-style check of one condition on every sampled edge.
`define SWFR_CHECK(lbl, cond, msg) `SWFR_ASSERT(lbl, (1'b1 |-> (cond)), msg)

`endif

// ----- hdl/swfr_pkg.sv -----
`default_nettype none

package swfr_pkg;

  localparam int MSG_BYTES_DEF = 19;

  localparam logic [7:0]  END_MARK   = 8'h2B;   // '+'
  localparam logic [7:0]  START_MARK = 8'h40;   // '@'
  localparam logic [7:0]  CHECK_INIT = 8'h00;
  localparam logic [31:0] WORD_RESET = 32'h3F80_0000;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_ACCEPT   = 2'd1,
    STATUS_MISMATCH = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic load;
    logic sum;
    logic eval;
  } swfr_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/sliding_window_frame_receiver.sv -----
// Frame receiver for a serial byte stream. Each byte transferred on the input
// side yields exactly one result: frame_status (0 no frame end, 1 frame
// accepted, 2 checksum mismatch) plus the four most recently accepted payload
// words, which hold 0x3F800000 after reset and change only with a result that
// reports an accepted frame. A byte first enters the MSG_BYTES-deep window,
// then passes the registered partial XOR stage, then the final XOR reduce,
// the checksum compare and the result register. The
// next byte is taken while a result waits on out_stall, but the evaluate step
// of that byte holds until the waiting result has been transferred. No
// clearing pass runs after reset.
`default_nettype none

module sliding_window_frame_receiver
  import swfr_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  frame_status,
  output logic      [31:0] word_one,
  output logic      [31:0] word_two,
  output logic      [31:0] word_three,
  output logic      [31:0] word_four
);

  swfr_cmd_t cmd;

  swfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  swfr_datapath #(
    .MSG_BYTES (MSG_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .rx_byte      (rx_byte),
    .frame_status (frame_status),
    .word_one     (word_one),
    .word_two     (word_two),
    .word_three   (word_three),
    .word_four    (word_four)
  );

endmodule

`default_nettype wire

// ----- hdl/swfr_datapath.sv -----
`default_nettype none

module swfr_datapath
  import swfr_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire swfr_cmd_t   cmd,
  input  wire logic [7:0]  rx_byte,
  output logic      [1:0]  frame_status,
  output logic      [31:0] word_one,
  output logic      [31:0] word_two,
  output logic      [31:0] word_three,
  output logic      [31:0] word_four
);

  localparam int FILL_W = $clog2(MSG_BYTES + 1);
  localparam int IDX_W  = $clog2(MSG_BYTES);
  localparam int NX     = MSG_BYTES - 3;      // checksummed bytes 2..MSG_BYTES-2
  localparam int NG     = (NX + 7) / 8;       // partial XOR groups

  logic [7:0]        win [MSG_BYTES];
  logic [FILL_W-1:0] fill;
  logic              end_seen;
  logic [7:0]        part [NG];
  logic [7:0]        part_x [NG];
  logic [7:0]        xor_all;
  logic [31:0]       held [4];
  frame_status_t     status;
  logic              full;

  assign full = (fill >= FILL_W'(MSG_BYTES));

  // First tree level: up to eight bytes per group.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_x[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (8 * g + j < NX) begin
          part_x[g] = part_x[g] ^ win[2 + 8 * g + j];
        end
      end
    end
  end

  always_comb begin
    xor_all = CHECK_INIT;
    for (int g = 0; g < NG; g++) begin
      xor_all = xor_all ^ part[g];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      for (int g = 0; g < NG; g++) begin
        part[g] <= part_x[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MSG_BYTES; i++) begin
        win[i] <= '0;
      end
      fill     <= '0;
      end_seen <= 1'b0;
      status   <= STATUS_NONE;
      for (int k = 0; k < 4; k++) begin
        held[k] <= WORD_RESET;
      end
    end else begin
      if (cmd.load) begin
        if (full) begin
          // slide the window left, new byte takes the last place
          for (int i = 0; i < MSG_BYTES - 1; i++) begin
            win[i] <= win[i + 1];
          end
          win[MSG_BYTES - 1] <= rx_byte;
        end else begin
          for (int i = 0; i < MSG_BYTES; i++) begin
            if (fill[IDX_W-1:0] == IDX_W'(i)) begin
              win[i] <= rx_byte;
            end
          end
          fill <= fill + FILL_W'(1);
        end
        end_seen <= (rx_byte == END_MARK);
      end
      if (cmd.eval) begin
        if (end_seen && (win[0] == START_MARK)) begin
          if (xor_all == win[1]) begin
            for (int k = 0; k < 4; k++) begin
              held[k] <= {win[5 + 4 * k], win[4 + 4 * k], win[3 + 4 * k], win[2 + 4 * k]};
            end
            fill   <= '0;
            status <= STATUS_ACCEPT;
          end else begin
            status <= STATUS_MISMATCH;
          end
        end else begin
          status <= STATUS_NONE;
        end
      end
    end
  end

  assign frame_status = status;
  assign word_one     = held[0];
  assign word_two     = held[1];
  assign word_three   = held[2];
  assign word_four    = held[3];

endmodule

`default_nettype wire

// ----- hdl/swfr_ctrl.sv -----
`default_nettype none

module swfr_ctrl
  import swfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  output swfr_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_EVAL
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.sum  = (state == S_SUM);
    cmd.eval = (state == S_EVAL) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.eval) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          // hold until the previous result has been transferred
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/swfr_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module swfr_checker
  import swfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  frame_status,
  input wire logic [31:0] word_one,
  input wire logic [31:0] word_two,
  input wire logic [31:0] word_three,
  input wire logic [31:0] word_four
);

  // Status code 3 is never reported.
  `SWFR_CHECK(a_no_status_three, (!out_valid || (frame_status != 2'd3)), "frame_status is 3")

  // A new payload word shows only with a result that reports an accepted frame.
  `SWFR_ASSERT(a_word_with_accept, ((word_one != $past(word_one)) |-> (out_valid && (frame_status == STATUS_ACCEPT))), "word_one changed without accept")

  // One byte at a time: after a transfer in, the input side stalls.
  `SWFR_ASSERT(a_stall_after_take, ((in_valid && !in_stall) |=> in_stall), "byte taken on back-to-back cycles")

  // A stalled result stays on the port.
  `SWFR_ASSERT(a_out_hold, ((out_valid && out_stall) |=> (out_valid && $stable(frame_status) && $stable(word_one) && $stable(word_two) && $stable(word_three) && $stable(word_four))), "stalled result changed")

endmodule

bind sliding_window_frame_receiver swfr_checker u_swfr_checker (.*);

`default_nettype wire

// ----- tb/sv/swfr_frame_checker.sv -----
`timescale 1ns / 1ps

module swfr_frame_checker
  import swfr_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  frame_status,
  input  wire logic [31:0] word_one,
  input  wire logic [31:0] word_two,
  input  wire logic [31:0] word_three,
  input  wire logic [31:0] word_four,
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    frame_status_t     status;
    logic [3:0][31:0]  words;
  } frame_outcome_t;

  logic [7:0]     window [MSG_BYTES];
  int             fill;
  logic [31:0]    held [4];
  frame_outcome_t awaited_outcomes [$];

  // Slide or append the byte, then run the frame-end test on the new window.
  function automatic frame_outcome_t absorb_byte(input logic [7:0] b);
    frame_outcome_t r;
    logic [7:0]     sum;
    int             k;
    r.status = STATUS_NONE;
    sum = CHECK_INIT;
    if (fill >= MSG_BYTES) begin
      for (k = 0; k < MSG_BYTES - 1; k++) window[k] = window[k + 1];
      window[MSG_BYTES - 1] = b;
    end else begin
      window[fill] = b;
      fill++;
    end
    if (b == END_MARK && window[0] == START_MARK) begin
      for (k = 2; k <= MSG_BYTES - 2; k++) sum ^= window[k];
      if (sum == window[1]) begin
        for (k = 0; k < 4; k++) begin
          held[k] = {window[5 + 4 * k], window[4 + 4 * k], window[3 + 4 * k], window[2 + 4 * k]};
        end
        fill = 0;
        r.status = STATUS_ACCEPT;
      end else begin
        r.status = STATUS_MISMATCH;
      end
    end
    for (k = 0; k < 4; k++) r.words[k] = held[k];
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_outcome_t want;
    if (rst) begin
      for (int k = 0; k < MSG_BYTES; k++) window[k] = 8'h00;
      for (int k = 0; k < 4; k++) held[k] = WORD_RESET;
      fill = 0;
      awaited_outcomes.delete();
      outstanding <= 0;
    end else begin
      // Push first so a same-edge result still pops the oldest entry.
      if (in_valid && !in_stall) awaited_outcomes.push_back(absorb_byte(rx_byte));
      if (out_valid && !out_stall) begin
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d words %08h %08h %08h %08h",
                   $time, frame_status, word_one, word_two, word_three, word_four);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("frame_status", 32'(want.status), 32'(frame_status));
          check_field("word_one", want.words[0], word_one);
          check_field("word_two", want.words[1], word_two);
          check_field("word_three", want.words[2], word_three);
          check_field("word_four", want.words[3], word_four);
        end
      end
      outstanding <= awaited_outcomes.size();
    end
  end

endmodule

// ----- tb/sv/tb_sliding_window_frame_receiver.sv -----
`timescale 1ns / 1ps

module tb_sliding_window_frame_receiver;
  import swfr_pkg::*;

  localparam int LONG_HOLD   = 64;
  localparam int QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  frame_status;
  logic [31:0] word_one;
  logic [31:0] word_two;
  logic [31:0] word_three;
  logic [31:0] word_four;

  int mismatches;
  int outstanding;
  int sent_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Payload XORs to '+', so a later "@+" closes a frame on stale bytes.
  logic [7:0] seed_payload [16] = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                                    8'h40, 8'h80, 8'h55, 8'hAA, 8'h12, 8'h34, 8'h56, 8'hA4};

  sliding_window_frame_receiver u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .word_one     (word_one),
    .word_two     (word_two),
    .word_three   (word_three),
    .word_four    (word_four)
  );

  swfr_frame_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .word_one     (word_one),
    .word_two     (word_two),
    .word_three   (word_three),
    .word_four    (word_four),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver side: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      hold_served <= hold_ticket;
      hold_left <= LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one byte, idling first at random, and hold it until the transfer.
  task automatic push_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Drop the offer so the last byte is not taken again, then let results drain.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // '@', checksum, payload bytes, '+'; keep < 16 ends the frame early.
  task automatic send_frame(input bit corrupt, input int keep);
    logic [7:0] body [16];
    logic [7:0] sum;
    int         k;
    sum = CHECK_INIT;
    for (k = 0; k < 16; k++) begin
      case ($urandom_range(19))
        0:       body[k] = END_MARK;
        1:       body[k] = START_MARK;
        default: body[k] = 8'($urandom_range(255));
      endcase
      sum ^= body[k];
    end
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    push_byte(START_MARK);
    push_byte(sum);
    for (k = 0; k < keep; k++) push_byte(body[k]);
    push_byte(END_MARK);
  endtask

  task automatic run_traffic(input int target);
    int pick;
    while (sent_count < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(pick < 10, 16);
      end else if (pick < 85) begin
        send_frame(1'($urandom_range(1)), int'($urandom_range(15)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(9))
            0:       push_byte(START_MARK);
            1:       push_byte(END_MARK);
            default: push_byte(8'($urandom_range(255)));
          endcase
        end
      end
    end
  endtask

  initial begin
    int k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Checksum byte is '+': closes an early frame against reset zeros.
    push_byte(START_MARK);
    push_byte(END_MARK);
    for (k = 0; k < 16; k++) push_byte(seed_payload[k]);
    push_byte(END_MARK);
    // Window is not cleared: "@+" matches on the stale payload.
    push_byte(START_MARK);
    push_byte(END_MARK);
    // Stale bytes no longer sum to the checksum byte.
    push_byte(START_MARK);
    push_byte(8'h11);
    push_byte(END_MARK);

    run_traffic(100);
    wait_drained();

    // Hold the receiver off while the sender keeps offering bytes.
    hold_ticket++;
    send_frame(1'b0, 16);
    repeat (8) push_byte(8'($urandom_range(255)));
    wait_drained();

    send_idle_pct = 69;
    run_traffic(200);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 69;
    run_traffic(300);
    wait_drained();

    send_idle_pct = 37;
    stall_pct = 37;
    run_traffic(420);
    wait_drained();
    repeat (12) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sliding_window_frame_receiver.f -----
+incdir+hdl
hdl/swfr_pkg.sv
hdl/swfr_datapath.sv
hdl/swfr_ctrl.sv
hdl/sliding_window_frame_receiver.sv
hdl/swfr_checker.sv
tb/sv/swfr_frame_checker.sv
tb/sv/tb_sliding_window_frame_receiver.sv
